// ----- rtl/orb_pkg.sv -----
// Shared types and constants for the overwriting ring buffer.
package orb_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int REQ_W   = 2;
  localparam int ENTRY_W = 32;
  localparam int SLOT_W  = 4;
  localparam int FILL_W  = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_ENQ  = 2'd0,
    REQ_DEQ  = 2'd1,
    REQ_PEEK = 2'd2,
    REQ_NOP  = 2'd3
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot_index;
    logic              overwrote;
    logic              read_valid;
    logic [FILL_W-1:0] fill_count;
    logic              is_full;
    logic              is_empty;
  } result_t;

endpackage

// ----- rtl/orb_ram.sv -----
// Generic single-port RAM with registered read.
module orb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ----- rtl/orb_ctrl.sv -----
// Head pointer, fill count and slot selection for the ring buffer.
module orb_ctrl import orb_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  req_t                     req_type,
  output logic                     ram_en,
  output logic                     ram_we,
  output logic [$clog2(DEPTH)-1:0] ram_addr,
  output result_t                  res
);

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;

  logic [ADDR_W-1:0] head, head_next, head_inc, tail;
  logic [CNT_W-1:0]  count, count_next;
  logic [SUM_W-1:0]  tail_sum;
  logic              full, empty;

  assign full     = count == CNT_W'(DEPTH);
  assign empty    = count == '0;
  assign head_inc = (head == ADDR_W'(DEPTH - 1)) ? '0 : head + 1'b1;
  assign tail_sum = SUM_W'(head) + SUM_W'(count);
  assign tail     = (tail_sum >= SUM_W'(DEPTH)) ? ADDR_W'(tail_sum - SUM_W'(DEPTH))
                                                : ADDR_W'(tail_sum);

  always_comb begin
    head_next      = head;
    count_next     = count;
    ram_en         = 1'b0;
    ram_we         = 1'b0;
    ram_addr       = head;
    res.slot_index = '0;
    res.overwrote  = 1'b0;
    res.read_valid = 1'b0;
    case (req_type)
      REQ_ENQ: begin
        ram_en = 1'b1;
        ram_we = 1'b1;
        if (full) begin
          head_next     = head_inc;
          res.overwrote = 1'b1;
        end else begin
          ram_addr   = tail;
          count_next = count + 1'b1;
        end
        res.slot_index = SLOT_W'(ram_addr);
      end
      REQ_DEQ, REQ_PEEK: begin
        if (!empty) begin
          ram_en         = 1'b1;
          res.read_valid = 1'b1;
          res.slot_index = SLOT_W'(head);
          if (req_type == REQ_DEQ) begin
            head_next  = head_inc;
            count_next = count - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    ram_en         = ram_en & accept;
    res.fill_count = FILL_W'(count_next);
    res.is_full    = count_next == CNT_W'(DEPTH);
    res.is_empty   = count_next == '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (accept) begin
      head  <= head_next;
      count <= count_next;
    end
  end

endmodule

// ----- rtl/overwriting_ring_buffer_core.sv -----
// Top level of the overwriting ring buffer: request handshake, record RAM, result register.
//
// Overwriting ring buffer of DEPTH records. Each request item (enqueue, dequeue, peek)
// gives one result item in the cycle after it is accepted, and a new request can be taken in
// every cycle while the result side keeps up. Pointer and count updates happen at the
// accepting edge; the record RAM is read or written in the same cycle and its registered
// read port supplies read_data for the result. in_stall is raised only while a result is
// held by out_stall. An enqueue into a full buffer overwrites the oldest record and flags it.
module overwriting_ring_buffer_core import orb_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [REQ_W-1:0]   req_type,
  input  logic [ENTRY_W-1:0] entry_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [ENTRY_W-1:0] read_data,
  output logic               read_valid,
  output logic [SLOT_W-1:0]  slot_index,
  output logic               overwrote,
  output logic [FILL_W-1:0]  fill_count,
  output logic               is_full,
  output logic               is_empty
);

  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int STORE_W = (DATA_WIDTH < ENTRY_W) ? DATA_WIDTH : ENTRY_W;

  logic                accept;
  logic                ram_en, ram_we;
  logic [ADDR_W-1:0]   ram_addr;
  logic [STORE_W-1:0]  ram_rdata;
  result_t             res_next, res;

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  orb_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .req_type (req_t'(req_type)),
    .ram_en   (ram_en),
    .ram_we   (ram_we),
    .ram_addr (ram_addr),
    .res      (res_next)
  );

  orb_ram #(
    .WIDTH(STORE_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (entry_data[STORE_W-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  assign read_data  = res.read_valid ? ENTRY_W'(ram_rdata) : '0;
  assign read_valid = res.read_valid;
  assign slot_index = res.slot_index;
  assign overwrote  = res.overwrote;
  assign fill_count = res.fill_count;
  assign is_full    = res.is_full;
  assign is_empty   = res.is_empty;

endmodule
